[src/mi4_pkg.sv]
// Shared types, constants and the multiply-accumulate program of the 4x4 inverter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package mi4_pkg;

   localparam int unsigned ELEM_WIDTH_DEF = 32;
   localparam int unsigned FRAC_BITS_DEF  = 16;
   localparam int unsigned QUEUE_DEPTH    = 4;
   localparam int unsigned NUM_OPS        = 76;
   localparam int unsigned STEP_BITS      = 7;

   typedef enum logic [1:0] {
      SRC_ELEM,
      SRC_DET2,
      SRC_COF
   } src_type;

   typedef enum logic [1:0] {
      DST_DET2,
      DST_COF,
      DST_DET
   } dst_type;

   typedef struct packed {
      logic [3:0] a_idx;
      src_type    b_src;
      logic [3:0] b_idx;
      logic       neg;
      logic       first;
      logic       last;
      dst_type    dst;
      logic [3:0] dst_idx;
   } op_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] idx;
   } q_head_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_OPA,
      ST_OPB,
      ST_MUL,
      ST_PREP,
      ST_DIV_WAIT,
      ST_OUT
   } back_state_type;

   // 2x2 determinant slot: row pair rp (0: rows 0/1, 1: rows 2/3), columns x < y
   function automatic logic [3:0] det2_index(input int rp, input int x, input int y);
      int n;
      logic [3:0] r;
      n = 0;
      r = '0;
      for (int c1 = 0; c1 < 4; c1++) begin
         for (int c2 = c1 + 1; c2 < 4; c2++) begin
            if (c1 == x && c2 == y) begin
               r = 4'(rp * 6 + n);
            end
            n++;
         end
      end
      return r;
   endfunction

   // 24 terms of 2x2 minors, 48 cofactor terms, 4 determinant terms
   function automatic op_type op_entry(input logic [STEP_BITS-1:0] step);
      op_type o;
      int n;
      int cnt;
      int ru;
      int p;
      int x;
      int y;
      o = '{a_idx: '0, b_src: SRC_ELEM, b_idx: '0, neg: 1'b0, first: 1'b0,
            last: 1'b0, dst: DST_DET2, dst_idx: '0};
      n = 0;
      for (int rp = 0; rp < 2; rp++) begin
         cnt = 0;
         for (int c1 = 0; c1 < 4; c1++) begin
            for (int c2 = c1 + 1; c2 < 4; c2++) begin
               for (int t = 0; t < 2; t++) begin
                  if (n == int'(step)) begin
                     ru = 2 * rp;
                     o.b_src   = SRC_ELEM;
                     o.dst     = DST_DET2;
                     o.dst_idx = 4'(rp * 6 + cnt);
                     if (t == 0) begin
                        o.a_idx = 4'(ru * 4 + c1);
                        o.b_idx = 4'((ru + 1) * 4 + c2);
                        o.neg   = 1'b0;
                        o.first = 1'b1;
                        o.last  = 1'b0;
                     end else begin
                        o.a_idx = 4'(ru * 4 + c2);
                        o.b_idx = 4'((ru + 1) * 4 + c1);
                        o.neg   = 1'b1;
                        o.first = 1'b0;
                        o.last  = 1'b1;
                     end
                  end
                  n++;
               end
               cnt++;
            end
         end
      end
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            p = 0;
            for (int k = 0; k < 4; k++) begin
               if (k != c) begin
                  x = -1;
                  y = -1;
                  for (int m = 0; m < 4; m++) begin
                     if (m != c && m != k) begin
                        if (x < 0) x = m;
                        else y = m;
                     end
                  end
                  if (n == int'(step)) begin
                     o.a_idx   = 4'((r ^ 1) * 4 + k);
                     o.b_src   = SRC_DET2;
                     o.b_idx   = det2_index((r < 2) ? 1 : 0, x, y);
                     o.neg     = ((p + r + c) % 2) != 0;
                     o.first   = (p == 0);
                     o.last    = (p == 2);
                     o.dst     = DST_COF;
                     o.dst_idx = 4'(r * 4 + c);
                  end
                  n++;
                  p++;
               end
            end
         end
      end
      for (int c = 0; c < 4; c++) begin
         if (n == int'(step)) begin
            o.a_idx   = 4'(c);
            o.b_src   = SRC_COF;
            o.b_idx   = 4'(c);
            o.neg     = 1'b0;
            o.first   = (c == 0);
            o.last    = (c == 3);
            o.dst     = DST_DET;
            o.dst_idx = '0;
         end
         n++;
      end
      return o;
   endfunction

endpackage
`default_nettype wire

[src/mi4_front.sv]
// Input side: element counter and short queue of tagged elements towards the back end.
// Depends on mi4_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mi4_front #(
   parameter int unsigned ELEM_WIDTH = mi4_pkg::ELEM_WIDTH_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           push,
   output logic                          full,
   input  wire  signed [ELEM_WIDTH-1:0]  req_element,
   output mi4_pkg::q_head_type           head,
   output logic signed [ELEM_WIDTH-1:0]  head_element,
   input  wire                           head_pop
);
   import mi4_pkg::*;

   localparam int unsigned DEPTH = QUEUE_DEPTH;
   localparam int unsigned PW    = $clog2(DEPTH);
   localparam int unsigned CNTW  = $clog2(DEPTH + 1);

   logic signed [ELEM_WIDTH-1:0] elem_q_ff [DEPTH];
   logic [3:0]                   idx_q_ff  [DEPTH];
   logic [PW-1:0]                wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]                rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]              count_ff, count_in;
   logic [3:0]                   load_count_ff, load_count_in;
   logic                         accept;
   logic                         take;

   assign full         = (count_ff == CNTW'(DEPTH));
   assign accept       = push && !full;
   assign take         = head_pop && head.valid;
   assign head.valid   = (count_ff != '0);
   assign head.idx     = idx_q_ff[rd_ptr_ff];
   assign head_element = elem_q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in     = accept ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in     = take ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      load_count_in = accept ? 4'(load_count_ff + 1'b1) : load_count_ff;
      count_in      = count_ff;
      if (accept && !take) count_in = CNTW'(count_ff + 1'b1);
      else if (take && !accept) count_in = CNTW'(count_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         load_count_ff <= '0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         load_count_ff <= load_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         elem_q_ff[wr_ptr_ff] <= req_element;
         idx_q_ff[wr_ptr_ff]  <= load_count_ff;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(DEPTH))
      else $error("queue over-filled");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (accept && !take) |=> count_ff == CNTW'($past(count_ff) + 1'b1))
      else $error("queue count missed a transfer");
   a_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && load_count_ff == 4'hF) |=> load_count_ff == '0)
      else $error("element counter did not wrap");
`endif

endmodule
`default_nettype wire

[src/mi4_mul.sv]
// Bit-serial signed multiplier: narrow element times wide operand, one bit a cycle.
// Depends on mi4_pkg for defaults only.
`timescale 1ns / 1ps
`default_nettype none
module mi4_mul #(
   parameter int unsigned ELEM_WIDTH = mi4_pkg::ELEM_WIDTH_DEF,
   parameter int unsigned ACC_WIDTH  = 4 * mi4_pkg::ELEM_WIDTH_DEF + 5
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  wire  [ELEM_WIDTH-1:0] a,
   input  wire  [ACC_WIDTH-1:0]  b,
   output logic [ACC_WIDTH-1:0]  product,
   output logic                  done
);
   import mi4_pkg::*;

   localparam int unsigned CW = $clog2(ELEM_WIDTH);

   logic [ACC_WIDTH-1:0]  mcand_ff;
   logic [ELEM_WIDTH-1:0] mplier_ff;
   logic [ACC_WIDTH-1:0]  prod_ff, prod_in;
   logic [CW-1:0]         cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [ACC_WIDTH-1:0]  addend;
   logic                  top_bit;

   assign product = prod_ff;
   assign done    = done_ff;
   assign top_bit = (cnt_ff == CW'(ELEM_WIDTH - 1));
   assign addend  = mplier_ff[0] ? mcand_ff : '0;
   assign prod_in = top_bit ? prod_ff - addend : prod_ff + addend;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && top_bit) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff  <= b;
         mplier_ff <= a;
         prod_ff   <= '0;
         cnt_ff    <= '0;
      end else if (busy_ff) begin
         mcand_ff  <= {mcand_ff[ACC_WIDTH-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[ELEM_WIDTH-1:1]};
         prod_ff   <= prod_in;
         cnt_ff    <= CW'(cnt_ff + 1'b1);
      end
   end

endmodule
`default_nettype wire

[src/mi4_div.sv]
// Restoring unsigned divider, one quotient bit a cycle.
// Depends on mi4_pkg for defaults only.
`timescale 1ns / 1ps
`default_nettype none
module mi4_div #(
   parameter int unsigned NUM_WIDTH = 3 * mi4_pkg::ELEM_WIDTH_DEF + 3 + 2 * mi4_pkg::FRAC_BITS_DEF,
   parameter int unsigned DEN_WIDTH = 4 * mi4_pkg::ELEM_WIDTH_DEF + 5
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire  [NUM_WIDTH-1:0] num,
   input  wire  [DEN_WIDTH-1:0] den,
   output logic [NUM_WIDTH-1:0] quot,
   output logic                 done
);
   import mi4_pkg::*;

   localparam int unsigned CW = $clog2(NUM_WIDTH);

   logic [DEN_WIDTH-1:0] rem_ff;
   logic [DEN_WIDTH-1:0] den_ff;
   logic [NUM_WIDTH-1:0] num_ff;
   logic [NUM_WIDTH-1:0] quot_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DEN_WIDTH:0]   trial;
   logic [DEN_WIDTH:0]   diff;
   logic                 fits;
   logic                 final_bit;

   assign trial     = {rem_ff, num_ff[NUM_WIDTH-1]};
   assign diff      = trial - {1'b0, den_ff};
   assign fits      = (trial >= {1'b0, den_ff});
   assign final_bit = (cnt_ff == CW'(NUM_WIDTH - 1));
   assign quot      = quot_ff;
   assign done      = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && final_bit) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         den_ff  <= den;
         num_ff  <= num;
         quot_ff <= '0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff  <= fits ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
         num_ff  <= {num_ff[NUM_WIDTH-2:0], 1'b0};
         quot_ff <= {quot_ff[NUM_WIDTH-2:0], fits};
         cnt_ff  <= CW'(cnt_ff + 1'b1);
      end
   end

endmodule
`default_nettype wire

[src/mi4_back.sv]
// Back end: matrix store, cofactor sequencer over the shared multiplier, divider and result register.
// Depends on mi4_pkg, mi4_mul and mi4_div.
`timescale 1ns / 1ps
`default_nettype none
module mi4_back #(
   parameter int unsigned ELEM_WIDTH = mi4_pkg::ELEM_WIDTH_DEF,
   parameter int unsigned FRAC_BITS  = mi4_pkg::FRAC_BITS_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire  mi4_pkg::q_head_type     head,
   input  wire  signed [ELEM_WIDTH-1:0]  head_element,
   output logic                          head_pop,
   output logic                          empty,
   input  wire                           pop,
   output logic signed [ELEM_WIDTH-1:0]  rsp_inverse_element,
   output logic                          rsp_is_singular,
   output logic                          rsp_saturated,
   output logic                          rsp_last_of_run
);
   import mi4_pkg::*;

   localparam int unsigned W   = ELEM_WIDTH;
   localparam int unsigned P2W = 2 * W + 1;
   localparam int unsigned CFW = 3 * W + 3;
   localparam int unsigned AW  = 4 * W + 5;
   localparam int unsigned NW  = CFW + 2 * FRAC_BITS;
   localparam logic          ONE_SAT = (FRAC_BITS > W - 2);
   localparam logic [W-1:0]  MAX_VAL = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  MIN_VAL = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0]  ONE_VAL = ONE_SAT ? MAX_VAL : (W'(1) << FRAC_BITS);
   localparam logic [NW-1:0] LIM_POS = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [NW-1:0] LIM_NEG = {{(NW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

   back_state_type state_ff, state_in;

   logic [W-1:0]         store_ff [16];
   logic [P2W-1:0]       det2_ff  [12];
   logic [CFW-1:0]       cof_ff   [16];
   logic [AW-1:0]        det_ff;
   logic [AW-1:0]        acc_ff;
   logic [W-1:0]         a_ff;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [3:0]           k_ff, k_in;
   logic                 nneg_ff;
   logic [W-1:0]         res_ff;
   logic                 res_sat_ff;

   logic [W-1:0]         out_elem_ff;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_sing_ff;
   logic                 out_sat_ff;
   logic                 out_last_ff;

   op_type               op;
   logic [3:0]           rd_idx;
   logic [W-1:0]         store_rd;
   logic [AW-1:0]        b_val;
   logic [AW-1:0]        acc_sum;
   logic [AW-1:0]        acc_base;
   logic                 mul_start;
   logic [AW-1:0]        mul_prod;
   logic                 mul_done;
   logic                 div_start;
   logic [NW-1:0]        div_quot;
   logic                 div_done;
   logic                 singular;
   logic                 det_neg;
   logic [AW-1:0]        det_mag;
   logic [3:0]           cof_sel;
   logic [CFW-1:0]       cof_val;
   logic [CFW-1:0]       cof_mag;
   logic [NW-1:0]        div_num;
   logic                 q_big;
   logic [W-1:0]         q_val;
   logic                 load_out;
   logic                 id_diag;

   assign op       = op_entry(step_ff);
   assign rd_idx   = (state_ff == ST_OPA) ? op.a_idx : op.b_idx;
   assign store_rd = store_ff[rd_idx];

   always_comb begin
      unique case (op.b_src)
         SRC_ELEM: b_val = {{(AW-W){store_rd[W-1]}}, store_rd};
         SRC_DET2: b_val = {{(AW-P2W){det2_ff[op.b_idx][P2W-1]}}, det2_ff[op.b_idx]};
         SRC_COF:  b_val = {{(AW-CFW){cof_ff[op.b_idx][CFW-1]}}, cof_ff[op.b_idx]};
         default:  b_val = '0;
      endcase
   end

   assign acc_base = op.first ? '0 : acc_ff;
   assign acc_sum  = op.neg ? acc_base - mul_prod : acc_base + mul_prod;

   assign singular = (det_ff == '0);
   assign det_neg  = det_ff[AW-1];
   assign det_mag  = det_neg ? AW'(-det_ff) : det_ff;
   assign cof_sel  = {k_ff[1:0], k_ff[3:2]};
   assign cof_val  = cof_ff[cof_sel];
   assign cof_mag  = cof_val[CFW-1] ? CFW'(-cof_val) : cof_val;
   assign div_num  = {cof_mag, {(2*FRAC_BITS){1'b0}}};
   assign id_diag  = (k_ff[1:0] == k_ff[3:2]);

   assign q_big = nneg_ff ? (div_quot > LIM_NEG) : (div_quot > LIM_POS);
   always_comb begin
      if (q_big) q_val = nneg_ff ? MIN_VAL : MAX_VAL;
      else if (nneg_ff) q_val = W'(-div_quot[W-1:0]);
      else q_val = div_quot[W-1:0];
   end

   assign load_out = (state_ff == ST_OUT) && (!out_valid_ff || pop);

   mi4_mul #(
      .ELEM_WIDTH (W),
      .ACC_WIDTH  (AW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (a_ff),
      .b       (b_val),
      .product (mul_prod),
      .done    (mul_done)
   );

   mi4_div #(
      .NUM_WIDTH (NW),
      .DEN_WIDTH (AW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (det_mag),
      .quot  (div_quot),
      .done  (div_done)
   );

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      k_in      = k_ff;
      head_pop  = 1'b0;
      mul_start = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_FILL: begin
            head_pop = 1'b1;
            if (head.valid && head.idx == 4'hF) begin
               step_in  = '0;
               state_in = ST_OPA;
            end
         end
         ST_OPA: state_in = ST_OPB;
         ST_OPB: begin
            mul_start = 1'b1;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            if (mul_done) begin
               if (step_ff == STEP_BITS'(NUM_OPS - 1)) begin
                  k_in     = '0;
                  state_in = ST_PREP;
               end else begin
                  step_in  = STEP_BITS'(step_ff + 1'b1);
                  state_in = ST_OPA;
               end
            end
         end
         ST_PREP: begin
            if (singular) begin
               state_in = ST_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (load_out) begin
               k_in     = 4'(k_ff + 1'b1);
               state_in = (k_ff == 4'hF) ? ST_FILL : ST_PREP;
            end
         end
         default: state_in = ST_FILL;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out) out_valid_in = 1'b1;
      else if (pop) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         step_ff      <= '0;
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FILL && head.valid) begin
         store_ff[head.idx] <= head_element;
      end
      if (state_ff == ST_OPA) begin
         a_ff <= store_rd;
      end
      if (state_ff == ST_MUL && mul_done) begin
         acc_ff <= acc_sum;
         if (op.last) begin
            unique case (op.dst)
               DST_DET2: det2_ff[op.dst_idx] <= acc_sum[P2W-1:0];
               DST_COF:  cof_ff[op.dst_idx]  <= acc_sum[CFW-1:0];
               DST_DET:  det_ff              <= acc_sum;
               default:  det_ff              <= acc_sum;
            endcase
         end
      end
      if (state_ff == ST_PREP) begin
         nneg_ff <= cof_val[CFW-1] ^ det_neg;
         if (singular) begin
            res_ff     <= id_diag ? ONE_VAL : '0;
            res_sat_ff <= id_diag && ONE_SAT;
         end
      end
      if (state_ff == ST_DIV_WAIT && div_done) begin
         res_ff     <= q_val;
         res_sat_ff <= q_big;
      end
      if (load_out) begin
         out_elem_ff <= res_ff;
         out_sing_ff <= singular;
         out_sat_ff  <= res_sat_ff;
         out_last_ff <= (k_ff == 4'hF);
      end
   end

   assign empty               = !out_valid_ff;
   assign rsp_inverse_element = out_elem_ff;
   assign rsp_is_singular     = out_sing_ff;
   assign rsp_saturated       = out_sat_ff;
   assign rsp_last_of_run     = out_last_ff;

`ifndef NO_ASSERTIONS
   a_no_div_singular: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_WAIT) |-> det_ff != '0)
      else $error("division started on a zero determinant");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> step_ff < STEP_BITS'(NUM_OPS))
      else $error("program step out of range");
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (load_out && k_ff == 4'hF) |=> (out_last_ff && out_valid_ff))
      else $error("sixteenth result not marked last");
`endif

endmodule
`default_nettype wire

[src/matrix_inverse_4x4.sv]
// After the sixteenth element, the back end runs the serial multiply-accumulate program and then
// one bit-serial division per result, before the last result is loaded.
// A new matrix is taken from the input queue only after the last result of the one before is loaded;
// the pace is set by the single shared serial multiplier and the one-bit-a-cycle divider.
// A singular matrix skips the division.
// Synchronous reset empties the input queue and result register and restarts the element count.
`timescale 1ns / 1ps
`default_nettype none
module matrix_inverse_4x4 #(
   parameter int unsigned ELEM_WIDTH = mi4_pkg::ELEM_WIDTH_DEF,
   parameter int unsigned FRAC_BITS  = mi4_pkg::FRAC_BITS_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           push,
   output logic                          full,
   input  wire  signed [ELEM_WIDTH-1:0]  req_element,
   output logic                          empty,
   input  wire                           pop,
   output logic signed [ELEM_WIDTH-1:0]  rsp_inverse_element,
   output logic                          rsp_is_singular,
   output logic                          rsp_saturated,
   output logic                          rsp_last_of_run
);
   import mi4_pkg::*;

   q_head_type                   head;
   logic signed [ELEM_WIDTH-1:0] head_element;
   logic                         head_pop;

   mi4_front #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_element  (req_element),
      .head         (head),
      .head_element (head_element),
      .head_pop     (head_pop)
   );

   mi4_back #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .head_element        (head_element),
      .head_pop            (head_pop),
      .empty               (empty),
      .pop                 (pop),
      .rsp_inverse_element (rsp_inverse_element),
      .rsp_is_singular     (rsp_is_singular),
      .rsp_saturated       (rsp_saturated),
      .rsp_last_of_run     (rsp_last_of_run)
   );

endmodule
`default_nettype wire
